>>> design/ssm_pkg.sv
// Shared types and constants for the spatial softmax map block.
// No dependencies; ssm_exp, ssm_div and the top level refer to this package by scoped names.
package ssm_pkg;

	localparam int SCORE_W    = 12;  // signed Q3.8 score
	localparam int EXP_W      = 28;  // Q12.16 exponential
	localparam int SUM_W      = 40;  // running sum of exponentials
	localparam int PROB_W     = 16;  // unsigned Q0.16 probability
	localparam int SIDE_CFG_W = 7;   // map_side register

	localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 7'd64;

	// e and 1/e in Q24, matching the 14-term series with truncated terms
	localparam logic [25:0] E_Q24    = 26'd45605201;
	localparam logic [25:0] EINV_Q24 = 26'd6171993;

	localparam logic [EXP_W-1:0] EXP_MAX = '1;

	typedef struct packed {
		logic             done;
		logic [EXP_W-1:0] value;
	} exp_rsp_t;

	typedef struct packed {
		logic              done;
		logic [PROB_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> design/ssm_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module ssm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/ssm_exp.sv
// Digit-serial fixed-point exp of a Q3.8 score, result in Q12.16.
// Uses ssm_pkg for widths, the e and 1/e constants and the response struct.
module ssm_exp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ssm_pkg::SCORE_W-1:0]  score,
	output ssm_pkg::exp_rsp_t            rsp
);

	localparam int SERIES_TERMS = 14;
	localparam int DIV_BYTES    = 5;  // 40-bit dividend, one byte per cycle
	localparam int MUL_DIGITS   = 7;  // 28-bit constant, one nibble per cycle

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMUL,
		ST_SDIV,
		ST_ROUND,
		ST_SCALE,
		ST_FINISH
	} state_t;

	state_t                        state_q;
	logic [7:0]                    f_q;
	logic [7:0]                    fsh_q;
	logic                          neg_q;
	logic [3:0]                    cnt_q;
	logic [3:0]                    k_q;
	logic                          dig_q;
	logic [32:0]                   term_q;
	logic [33:0]                   acc_q;
	logic [40:0]                   prod_q;
	logic [39:0]                   dvd_q;
	logic [3:0]                    rem_q;
	logic [2:0]                    byte_q;
	logic [35:0]                   r_q;
	logic [61:0]                   mprod_q;
	logic [27:0]                   bsh_q;
	logic [2:0]                    mdig_q;
	logic                          done_q;
	logic [ssm_pkg::EXP_W-1:0]     value_q;

	// Eight restoring steps of a divide by a small constant; remainder stays below k.
	function automatic logic [11:0] div8(input logic [3:0] rem_in, input logic [7:0] din,
		input logic [3:0] dvs);
		logic [3:0] rem;
		logic [4:0] trial;
		logic [7:0] q;
		rem = rem_in;
		q   = '0;
		for (int i = 7; i >= 0; i--) begin
			trial = {rem, din[i]};
			if (trial >= {1'b0, dvs}) begin
				rem  = 4'(trial - {1'b0, dvs});
				q[i] = 1'b1;
			end else begin
				rem = trial[3:0];
			end
		end
		return {rem, q};
	endfunction

	logic [36:0]                   term_pp;
	logic [40:0]                   prod_nx;
	logic [11:0]                   div_res;
	logic [39:0]                   dvd_nx;
	logic [33:0]                   acc_nx;
	logic [27:0]                   bconst;
	logic [39:0]                   r_pp;
	logic [61:0]                   mprod_nx;
	logic [37:0]                   r_scaled;
	logic [28:0]                   r_out;
	logic [ssm_pkg::EXP_W-1:0]     r_capped;

	always_comb begin
		term_pp  = term_q * fsh_q[7:4];
		prod_nx  = {prod_q[36:0], 4'b0} + {4'b0, term_pp};
		div_res  = div8(rem_q, dvd_q[39:32], k_q);
		dvd_nx   = {dvd_q[31:0], div_res[7:0]};
		acc_nx   = acc_q + 34'(dvd_nx[32:0]);
		bconst   = neg_q ? 28'(ssm_pkg::EINV_Q24) : 28'(ssm_pkg::E_Q24);
		r_pp     = r_q * bsh_q[27:24];
		mprod_nx = {mprod_q[57:0], 4'b0} + {22'b0, r_pp};
		r_scaled = 38'((mprod_nx + 62'd8388608) >> 24);
		r_out    = 29'(({1'b0, r_q} + 37'd128) >> 8);
		r_capped = (r_out > {1'b0, ssm_pkg::EXP_MAX}) ? ssm_pkg::EXP_MAX : r_out[27:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			f_q     <= '0;
			fsh_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			k_q     <= '0;
			dig_q   <= 1'b0;
			term_q  <= '0;
			acc_q   <= '0;
			prod_q  <= '0;
			dvd_q   <= '0;
			rem_q   <= '0;
			byte_q  <= '0;
			r_q     <= '0;
			mprod_q <= '0;
			bsh_q   <= '0;
			mdig_q  <= '0;
			done_q  <= 1'b0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						f_q     <= score[7:0];
						fsh_q   <= score[7:0];
						neg_q   <= score[11];
						cnt_q   <= score[11] ? 4'(~score[11:8] + 4'd1) : score[11:8];
						term_q  <= {1'b1, 32'b0};
						acc_q   <= {2'b01, 32'b0};
						k_q     <= 4'd1;
						dig_q   <= 1'b0;
						prod_q  <= '0;
						state_q <= ST_SMUL;
					end
				end
				ST_SMUL: begin
					// multiply the term by f, high nibble first
					prod_q <= prod_nx;
					fsh_q  <= {fsh_q[3:0], 4'b0};
					dig_q  <= ~dig_q;
					if (dig_q) begin
						dvd_q   <= {7'b0, prod_nx[40:8]};
						rem_q   <= '0;
						byte_q  <= '0;
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					dvd_q  <= dvd_nx;
					rem_q  <= div_res[11:8];
					byte_q <= byte_q + 3'd1;
					if (byte_q == 3'(DIV_BYTES - 1)) begin
						term_q <= dvd_nx[32:0];
						acc_q  <= acc_nx;
						if (k_q == 4'(SERIES_TERMS)) begin
							state_q <= ST_ROUND;
						end else begin
							k_q     <= k_q + 4'd1;
							prod_q  <= '0;
							fsh_q   <= f_q;
							state_q <= ST_SMUL;
						end
					end
				end
				ST_ROUND: begin
					r_q     <= 36'(({1'b0, acc_q} + 35'd128) >> 8);
					mprod_q <= '0;
					mdig_q  <= '0;
					bsh_q   <= bconst;
					state_q <= (cnt_q == 4'd0) ? ST_FINISH : ST_SCALE;
				end
				ST_SCALE: begin
					// one Q24 product by e or 1/e per integer unit of the score
					mprod_q <= mprod_nx;
					bsh_q   <= {bsh_q[23:0], 4'b0};
					mdig_q  <= mdig_q + 3'd1;
					if (mdig_q == 3'(MUL_DIGITS - 1)) begin
						r_q     <= r_scaled[35:0];
						cnt_q   <= cnt_q - 4'd1;
						mprod_q <= '0;
						mdig_q  <= '0;
						bsh_q   <= bconst;
						if (cnt_q == 4'd1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					value_q <= r_capped;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

>>> design/ssm_div.sv
// Bit-serial fractional divider: floor(dividend * 2^16 / divisor), saturated to 16 bits.
// Uses ssm_pkg for widths and the response struct. A zero divisor gives a zero quotient.
module ssm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssm_pkg::EXP_W-1:0]   dividend,
	input  logic [ssm_pkg::SUM_W-1:0]   divisor,
	output ssm_pkg::div_rsp_t           rsp
);

	localparam int STEPS = ssm_pkg::PROB_W;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                        state_q;
	logic [ssm_pkg::SUM_W-1:0]     rem_q;
	logic [ssm_pkg::SUM_W-1:0]     dvs_q;
	logic [ssm_pkg::PROB_W-1:0]    quot_q;
	logic [$clog2(STEPS)-1:0]      step_q;
	logic                          done_q;

	logic [ssm_pkg::SUM_W:0]       trial;
	logic                          fits;
	logic [ssm_pkg::SUM_W-1:0]     dividend_ext;

	always_comb begin
		trial        = {rem_q, 1'b0};
		fits         = trial >= {1'b0, dvs_q};
		dividend_ext = ssm_pkg::SUM_W'(dividend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			dvs_q   <= '0;
			quot_q  <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (divisor == '0) begin
							quot_q <= '0;
							done_q <= 1'b1;
						end else if (dividend_ext >= divisor) begin
							// quotient would reach one or more: saturate
							quot_q <= '1;
							done_q <= 1'b1;
						end else begin
							rem_q   <= dividend_ext;
							dvs_q   <= divisor;
							quot_q  <= '0;
							step_q  <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					rem_q  <= fits ? ssm_pkg::SUM_W'(trial - {1'b0, dvs_q})
						: trial[ssm_pkg::SUM_W-1:0];
					quot_q <= {quot_q[ssm_pkg::PROB_W-2:0], fits};
					step_q <= step_q + 1'b1;
					if (step_q == $clog2(STEPS)'(STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> design/spatial_softmax_map.sv
// Top level of the spatial softmax map block.
// Depends on ssm_pkg, ssm_ram, ssm_exp and ssm_div.
//
// Softmax over one square heatmap of map_side x map_side signed Q3.8 scores. Feed the
// map's scores as load items (s_tuser = 0); each one is stored in the score RAM and its
// Q12.16 exponential is added to a saturating 40-bit sum. Once the map is full, every
// request item (s_tuser = 1) returns exp(score) * 2^16 / sum for the next stored score
// in load order as an unsigned Q0.16 value saturated at 65535, with m_tlast on the last
// element; the sum and both counters then clear for the next map. Loads beyond a full
// map and requests before the map is full are taken and dropped with no result.
// map_side clamps to 1..MAX_SIDE (zero acts as one); write it only while the block is
// idle. A new side count applies at once. Items are handled one at a time. The exp
// unit works digit by digit: a 14-term series (multiply by the fraction a nibble per
// cycle, then divide by the term index a byte per cycle) and then one multiply by e
// or 1/e per unit of the score's integer part n (-8..7). Unlike a load, a request
// also takes the score RAM read, the bit-serial divider and the output load. The
// output register lets a result wait for m_tready while the next item is accepted.
// The score RAM holds MAX_SIDE^2 entries and needs no clearing after reset.
module spatial_softmax_map #(
	parameter int MAX_SIDE = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,   // [11:0] score, [15:12] zero
	input  logic [0:0]                         s_tuser,   // [0] kind
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [15:0]                        m_tdata,   // [15:0] probability
	output logic                               m_tlast,
	// map_side register write
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssm_pkg::SIDE_CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam logic [7:0] MAX_SIDE_B = 8'(MAX_SIDE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_EXP,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                             state_q;
	logic [ssm_pkg::SIDE_CFG_W-1:0]     map_side_q;
	logic [ssm_pkg::SUM_W-1:0]          exp_sum_q;
	logic [CNT_W-1:0]                   load_count_q;
	logic [ADDR_W-1:0]                  emit_index_q;
	logic [ssm_pkg::PROB_W-1:0]         prob_q;
	logic                               m_tvalid_q;
	logic [ssm_pkg::PROB_W-1:0]         m_tdata_q;
	logic                               m_tlast_q;

	// Effective side and map size
	logic [7:0]                         side_ext;
	logic [7:0]                         side_clamp;
	logic [SIDE_W-1:0]                  side_eff;
	logic [2*SIDE_W-1:0]                side_sq;
	logic [CNT_W-1:0]                   total;

	always_comb begin
		side_ext   = {1'b0, map_side_q};
		side_clamp = (side_ext == 8'd0) ? 8'd1
			: ((side_ext > MAX_SIDE_B) ? MAX_SIDE_B : side_ext);
		side_eff   = SIDE_W'(side_clamp);
		side_sq    = side_eff * side_eff;
		total      = CNT_W'(side_sq);
	end

	// Input decode
	logic                               in_acc;
	logic                               map_full;
	logic                               load_go;
	logic                               req_go;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign map_full = (load_count_q >= total);
	assign load_go  = in_acc & ~s_tuser[0] & ~map_full;
	assign req_go   = in_acc & s_tuser[0] & map_full;

	// Score store
	logic [ssm_pkg::SCORE_W-1:0]        rd_score;

	ssm_ram #(
		.WIDTH (ssm_pkg::SCORE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_go),
		.waddr (load_count_q[ADDR_W-1:0]),
		.wdata (s_tdata[ssm_pkg::SCORE_W-1:0]),
		.raddr (emit_index_q),
		.rdata (rd_score)
	);

	// Exponential unit: started by a load directly, or by a request once the RAM read lands
	logic                               exp_start;
	logic [ssm_pkg::SCORE_W-1:0]        exp_score;
	ssm_pkg::exp_rsp_t                  exp_rsp;

	assign exp_start = load_go | (state_q == ST_READ);
	assign exp_score = (state_q == ST_READ) ? rd_score : s_tdata[ssm_pkg::SCORE_W-1:0];

	ssm_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.score  (exp_score),
		.rsp    (exp_rsp)
	);

	// Divider for the normalized probability
	logic                               div_start;
	ssm_pkg::div_rsp_t                  div_rsp;

	assign div_start = (state_q == ST_EXP) & exp_rsp.done;

	ssm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (exp_rsp.value),
		.divisor  (exp_sum_q),
		.rsp      (div_rsp)
	);

	// Sum update and end-of-map detection
	logic [ssm_pkg::SUM_W:0]            sum_add;
	logic [ssm_pkg::SUM_W-1:0]          sum_sat;
	logic [CNT_W:0]                     emit_next;
	logic                               is_last;
	logic                               out_free;
	logic                               out_load;

	always_comb begin
		sum_add   = {1'b0, exp_sum_q} + (ssm_pkg::SUM_W + 1)'(exp_rsp.value);
		sum_sat   = sum_add[ssm_pkg::SUM_W] ? '1 : sum_add[ssm_pkg::SUM_W-1:0];
		emit_next = (CNT_W + 1)'(emit_index_q) + 1'b1;
		// an index at or past a shrunken map end also closes the map
		is_last   = (emit_next >= {1'b0, total});
		out_free  = ~m_tvalid_q | m_tready;
		out_load  = (state_q == ST_OUT) & out_free;
	end

	// Configuration register: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_side_q <= ssm_pkg::SIDE_RESET;
		end else if (cfg_valid) begin
			map_side_q <= cfg_data;
		end
	end

	// Control sequence and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			exp_sum_q    <= '0;
			load_count_q <= '0;
			emit_index_q <= '0;
			prob_q       <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tlast_q    <= 1'b0;
		end else begin
			// load a new result, or drop the current one once the sink takes it
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_go) begin
						state_q <= ST_LOAD;
					end else if (req_go) begin
						state_q <= ST_READ;
					end
				end
				ST_LOAD: begin
					if (exp_rsp.done) begin
						exp_sum_q    <= sum_sat;
						load_count_q <= load_count_q + 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (exp_rsp.done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						prob_q  <= div_rsp.quot;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free, then advance the map
					if (out_free) begin
						m_tdata_q  <= prob_q;
						m_tlast_q  <= is_last;
						if (is_last) begin
							exp_sum_q    <= '0;
							load_count_q <= '0;
							emit_index_q <= '0;
						end else begin
							emit_index_q <= ADDR_W'(emit_next);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
